### design/dht_pkg.sv
package dht_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 20;

  localparam logic [CfgIdxW-1:0] CFG_FREQ_TOL  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH_TOL = 2'd1;

  localparam logic [19:0] FreqTolReset  = 20'd50;
  localparam logic [15:0] WidthTolReset = 16'd20;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_GET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_RENAME = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_BAD    = 3'd5
  } op_e;

  typedef struct packed {
    logic [31:0] id;
    logic [19:0] freq;
    logic [31:0] code;
    logic [7:0]  bits;
    logic [15:0] width;
    logic [7:0]  proto;
    logic [63:0] name;
  } rec_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] target;
    rec_t        rec;
  } cmd_t;

endpackage

### design/dht_front.sv
module dht_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    action_i,
  input  logic [31:0]   target_id_i,
  input  logic [19:0]   freq_khz_i,
  input  logic [31:0]   code_value_i,
  input  logic [7:0]    code_bits_i,
  input  logic [15:0]   pulse_width_us_i,
  input  logic [7:0]    protocol_num_i,
  input  logic [63:0]   name_tag_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output dht_pkg::cmd_t q_cmd_o
);
  import dht_pkg::*;

  op_e op;

  always_comb begin
    unique case (action_i)
      3'd0:    op = OP_ADD;
      3'd1:    op = OP_GET;
      3'd2:    op = OP_REMOVE;
      3'd3:    op = OP_RENAME;
      3'd4:    op = OP_CLEAR;
      default: op = OP_BAD;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.op         = op;
    q_cmd_o.target     = target_id_i;
    q_cmd_o.rec.id     = '0;
    q_cmd_o.rec.freq   = freq_khz_i;
    q_cmd_o.rec.code   = code_value_i;
    q_cmd_o.rec.bits   = code_bits_i;
    q_cmd_o.rec.width  = pulse_width_us_i;
    q_cmd_o.rec.proto  = protocol_num_i;
    q_cmd_o.rec.name   = name_tag_i;
  end

endmodule

### design/dht_queue.sv
module dht_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dht_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dht_pkg::cmd_t head_o
);
  import dht_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

### design/dht_back.sv
module dht_back #(
  parameter int unsigned DEPTH = dht_pkg::DepthDefault,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  dht_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  input  logic [19:0]   freq_tol_i,
  input  logic [15:0]   width_tol_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic          res_ok_o,
  output dht_pkg::rec_t res_rec_o,
  output logic [CW-1:0] res_count_o
);
  import dht_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_MV_RD, S_MV_WR, S_INS
  } st_e;

  st_e           st_q;
  cmd_t          cmd_q;
  logic [IW-1:0] idx_q, src_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   next_id_q;
  rec_t          mem [DEPTH];
  rec_t          rd_q;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  rec_t          wdata;
  logic          hit, last;
  logic [CW-1:0] cnt_cap;
  rec_t          ins_res;

  function automatic logic [19:0] absdiff20(input logic [19:0] a, input logic [19:0] b);
    absdiff20 = (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [15:0] absdiff16(input logic [15:0] a, input logic [15:0] b);
    absdiff16 = (a >= b) ? a - b : b - a;
  endfunction

  always_comb begin
    if (cmd_q.op == OP_ADD) begin
      hit = (rd_q.code == cmd_q.rec.code) && (rd_q.bits == cmd_q.rec.bits) &&
            (absdiff20(rd_q.freq, cmd_q.rec.freq) <= freq_tol_i) &&
            (absdiff16(rd_q.width, cmd_q.rec.width) <= width_tol_i);
    end else begin
      hit = (rd_q.id == cmd_q.target);
    end
  end

  // result of a successful add: only the new id
  always_comb begin
    ins_res    = '0;
    ins_res.id = next_id_q;
  end

  assign last    = (CW'(idx_q) + 1'b1 >= cnt_q);
  assign cnt_cap = (cnt_q == CW'(DEPTH)) ? CW'(DEPTH - 1) : cnt_q;
  assign q_pop_o = (st_q == S_IDLE) && !q_empty_i && !res_valid_o;

  always_comb begin
    raddr = (st_q == S_RD) ? idx_q : src_q;
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd_q;
    unique case (st_q)
      S_CMP: begin
        if (hit && cmd_q.op == OP_RENAME) begin
          we         = 1'b1;
          wdata.name = cmd_q.rec.name;
        end
      end
      S_MV_WR: begin
        we    = 1'b1;
        waddr = (cmd_q.op == OP_ADD) ? src_q + 1'b1 : src_q - 1'b1;
      end
      S_INS: begin
        we       = 1'b1;
        waddr    = '0;
        wdata    = cmd_q.rec;
        wdata.id = next_id_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      next_id_q   <= 32'd1;
      res_valid_o <= 1'b0;
      res_ok_o    <= 1'b0;
      res_rec_o   <= '0;
      res_count_o <= '0;
      cmd_q       <= '0;
      idx_q       <= '0;
      src_q       <= '0;
    end else begin
      if (res_valid_o && res_ready_i) begin
        res_valid_o <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (q_pop_o) begin
            cmd_q     <= q_head_i;
            idx_q     <= '0;
            res_ok_o  <= (q_head_i.op == OP_CLEAR);
            res_rec_o <= '0;
            unique case (q_head_i.op)
              OP_CLEAR: begin
                cnt_q       <= '0;
                res_count_o <= '0;
                res_valid_o <= 1'b1;
              end
              OP_BAD: begin
                res_count_o <= cnt_q;
                res_valid_o <= 1'b1;
              end
              OP_ADD: begin
                if (cnt_q == '0) begin
                  st_q <= S_INS;
                end else begin
                  st_q <= S_RD;
                end
              end
              default: begin
                if (cnt_q == '0) begin
                  res_count_o <= cnt_q;
                  res_valid_o <= 1'b1;
                end else begin
                  st_q <= S_RD;
                end
              end
            endcase
          end
        end
        S_RD: st_q <= S_CMP;
        S_CMP: begin
          if (hit) begin
            case (cmd_q.op)
              OP_ADD: begin
                res_count_o <= cnt_q;
                res_valid_o <= 1'b1;
                st_q        <= S_IDLE;
              end
              OP_GET: begin
                res_count_o <= cnt_q;
                res_ok_o    <= 1'b1;
                res_rec_o   <= rd_q;
                res_valid_o <= 1'b1;
                st_q        <= S_IDLE;
              end
              OP_RENAME: begin
                res_count_o  <= cnt_q;
                res_ok_o     <= 1'b1;
                res_rec_o.id <= cmd_q.target;
                res_valid_o  <= 1'b1;
                st_q         <= S_IDLE;
              end
              default: begin
                // remove: pull the older entries behind the hit down over it
                res_ok_o     <= 1'b1;
                res_rec_o.id <= cmd_q.target;
                if (last) begin
                  cnt_q       <= cnt_q - 1'b1;
                  res_count_o <= cnt_q - 1'b1;
                  res_valid_o <= 1'b1;
                  st_q        <= S_IDLE;
                end else begin
                  src_q <= idx_q + 1'b1;
                  st_q  <= S_MV_RD;
                end
              end
            endcase
          end else if (!last) begin
            idx_q <= idx_q + 1'b1;
            st_q  <= S_RD;
          end else if (cmd_q.op == OP_ADD) begin
            // no duplicate: drop oldest if full, then shift toward the tail
            cnt_q <= cnt_cap;
            if (cnt_cap == '0) begin
              st_q <= S_INS;
            end else begin
              src_q <= IW'(cnt_cap - 1'b1);
              st_q  <= S_MV_RD;
            end
          end else begin
            res_count_o <= cnt_q;
            res_valid_o <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        S_MV_RD: st_q <= S_MV_WR;
        S_MV_WR: begin
          if (cmd_q.op == OP_ADD) begin
            if (src_q == '0) begin
              st_q <= S_INS;
            end else begin
              src_q <= src_q - 1'b1;
              st_q  <= S_MV_RD;
            end
          end else if (CW'(src_q) + 1'b1 < cnt_q) begin
            src_q <= src_q + 1'b1;
            st_q  <= S_MV_RD;
          end else begin
            cnt_q       <= cnt_q - 1'b1;
            res_count_o <= cnt_q - 1'b1;
            res_valid_o <= 1'b1;
            st_q        <= S_IDLE;
          end
        end
        S_INS: begin
          cnt_q        <= cnt_q + 1'b1;
          res_count_o  <= cnt_q + 1'b1;
          res_ok_o     <= 1'b1;
          res_rec_o    <= ins_res;
          res_valid_o  <= 1'b1;
          next_id_q    <= next_id_q + 32'd1;
          st_q         <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

### design/dedup_history_table.sv
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------------
// input     | in        | in_valid_i / in_ready_o    | action_i .. name_tag_i
// result    | out       | out_valid_o / out_ready_i  | ok_o, out_*_o, entry_count_o
// config    | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one transaction at a time in the back end; a lookup reads one table slot per pass
// through S_RD and S_CMP (registered table read), a shift moves one slot per S_MV_RD/S_MV_WR pair
// add: search, shift toward the tail, then write the new entry in S_INS; get/rename: search
// clear and unknown actions finish straight from the idle state
// reset empties the table and sets the id counter to one; no clearing pass
// a two-entry queue lets the front take transactions while the back works or stalls
module dedup_history_table #(
  parameter int unsigned DEPTH = dht_pkg::DepthDefault,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dht_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dht_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   action_i,
  input  logic [31:0]                  target_id_i,
  input  logic [19:0]                  freq_khz_i,
  input  logic [31:0]                  code_value_i,
  input  logic [7:0]                   code_bits_i,
  input  logic [15:0]                  pulse_width_us_i,
  input  logic [7:0]                   protocol_num_i,
  input  logic [63:0]                  name_tag_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic [31:0]                  out_id_o,
  output logic [19:0]                  out_freq_khz_o,
  output logic [31:0]                  out_code_o,
  output logic [7:0]                   out_bits_o,
  output logic [15:0]                  out_width_us_o,
  output logic [7:0]                   out_protocol_o,
  output logic [63:0]                  out_name_o,
  output logic [CW-1:0]                entry_count_o
);
  import dht_pkg::*;

  // tolerance registers, to be written only while idle; the block does not enforce this
  logic [19:0] freq_tol_q;
  logic [15:0] width_tol_q;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_head;
  rec_t res_rec;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_tol_q  <= FreqTolReset;
      width_tol_q <= WidthTolReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FREQ_TOL:  freq_tol_q  <= cfg_data_i;
        CFG_WIDTH_TOL: width_tol_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // front: decode action, push command
  dht_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .target_id_i      (target_id_i),
    .freq_khz_i       (freq_khz_i),
    .code_value_i     (code_value_i),
    .code_bits_i      (code_bits_i),
    .pulse_width_us_i (pulse_width_us_i),
    .protocol_num_i   (protocol_num_i),
    .name_tag_i       (name_tag_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (q_in)
  );

  dht_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // back: table search, shift and result register
  dht_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .freq_tol_i  (freq_tol_q),
    .width_tol_i (width_tol_q),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_ok_o    (ok_o),
    .res_rec_o   (res_rec),
    .res_count_o (entry_count_o)
  );

  assign out_id_o       = res_rec.id;
  assign out_freq_khz_o = res_rec.freq;
  assign out_code_o     = res_rec.code;
  assign out_bits_o     = res_rec.bits;
  assign out_width_us_o = res_rec.width;
  assign out_protocol_o = res_rec.proto;
  assign out_name_o     = res_rec.name;

  // table occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entry_count_o <= CW'(DEPTH)))
    else $error("entry count beyond depth");

  // a failed operation carries no record contents
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (out_id_o == '0 && out_name_o == '0 && out_code_o == '0))
    else $error("failed result with record data");

  // the back only takes a command when the queue holds one
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // a pending result stays put until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_id_o)))
    else $error("result dropped while stalled");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import dht_pkg::*;

  localparam int unsigned Slots = 32;

  // one result as the table reports it
  typedef struct packed {
    logic       ok;
    logic [31:0] id;
    rec_t       rec;
    logic [5:0] count;
  } answer_t;

  logic        clk;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [31:0] target_id;
  logic [19:0] freq_khz;
  logic [31:0] code_value;
  logic [7:0]  code_bits;
  logic [15:0] pulse_width_us;
  logic [7:0]  protocol_num;
  logic [63:0] name_tag;
  logic        out_valid;
  logic        out_ready;
  logic        ok;
  logic [31:0] out_id;
  logic [19:0] out_freq_khz;
  logic [31:0] out_code;
  logic [7:0]  out_bits;
  logic [15:0] out_width_us;
  logic [7:0]  out_protocol;
  logic [63:0] out_name;
  logic [5:0]  entry_count;

  dedup_history_table dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .target_id_i     (target_id),
    .freq_khz_i      (freq_khz),
    .code_value_i    (code_value),
    .code_bits_i     (code_bits),
    .pulse_width_us_i(pulse_width_us),
    .protocol_num_i  (protocol_num),
    .name_tag_i      (name_tag),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .ok_o            (ok),
    .out_id_o        (out_id),
    .out_freq_khz_o  (out_freq_khz),
    .out_code_o      (out_code),
    .out_bits_o      (out_bits),
    .out_width_us_o  (out_width_us),
    .out_protocol_o  (out_protocol),
    .out_name_o      (out_name),
    .entry_count_o   (entry_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // shadow copy of the history table, newest record in slot 0
  rec_t        hist [Slots];
  int          hist_len;
  logic [31:0] id_counter;
  logic [19:0] freq_tol;
  logic [15:0] width_tol;

  answer_t answers_due [$];
  int      mismatches;
  int      results_seen;
  int      op_seen [8];
  int      dup_seen;
  int      evict_seen;

  // sender pacing: gap_mode 0 sends back to back, otherwise bursts with gaps
  int gap_mode;
  int burst_left;
  // receiver pacing and a one-shot long hold-off
  int stall_mode;
  int hold_req;
  int hold_cnt;
  int stall_phase;

  function automatic logic [31:0] dist32(logic [31:0] a, logic [31:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < hist_len; i++) begin
      if (hist[i].id == id) return i;
    end
    return -1;
  endfunction

  // apply one transaction to the shadow table and return what it must report
  function automatic answer_t table_update(logic [2:0] act, logic [31:0] tgt, rec_t r);
    answer_t a;
    int      s;
    bit      dup;
    a = '0;
    case (act)
      OP_ADD: begin
        dup = 1'b0;
        for (int i = 0; i < hist_len; i++) begin
          if (hist[i].code == r.code && hist[i].bits == r.bits &&
              dist32(hist[i].freq, r.freq) <= freq_tol &&
              dist32(hist[i].width, r.width) <= width_tol) begin
            dup = 1'b1;
            break;
          end
        end
        if (dup) dup_seen++;
        else begin
          if (hist_len >= Slots) begin
            hist_len = Slots - 1;
            evict_seen++;
          end
          for (int k = hist_len; k > 0; k--) hist[k] = hist[k-1];
          hist[0]    = r;
          hist[0].id = id_counter;
          hist_len++;
          a.ok = 1'b1;
          a.id = id_counter;
          id_counter = id_counter + 32'd1;
        end
      end
      OP_GET: begin
        s = find_slot(tgt);
        if (s >= 0) begin
          a.ok  = 1'b1;
          a.id  = hist[s].id;
          a.rec = hist[s];
        end
      end
      OP_REMOVE: begin
        s = find_slot(tgt);
        if (s >= 0) begin
          for (int k = s; k + 1 < hist_len; k++) hist[k] = hist[k+1];
          hist_len--;
          a.ok = 1'b1;
          a.id = tgt;
        end
      end
      OP_RENAME: begin
        s = find_slot(tgt);
        if (s >= 0) begin
          hist[s].name = r.name;
          a.ok = 1'b1;
          a.id = tgt;
        end
      end
      OP_CLEAR: begin
        hist_len = 0;
        a.ok = 1'b1;
      end
      default: ;
    endcase
    a.count = hist_len[5:0];
    return a;
  endfunction

  // offer one transaction and hold it until taken
  task automatic send_item(logic [2:0] act, logic [31:0] tgt, rec_t r);
    action         <= act;
    target_id      <= tgt;
    freq_khz       <= r.freq;
    code_value     <= r.code;
    code_bits      <= r.bits;
    pulse_width_us <= r.width;
    protocol_num   <= r.proto;
    name_tag       <= r.name;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    answers_due.push_back(table_update(act, tgt, r));
    op_seen[act]++;
    if (gap_mode != 0) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_mode == 1 ? 6 : 40)) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // let every outstanding result come back, then let the bench sit quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // both tolerance registers in one go, only while idle
  task automatic set_tolerances(logic [19:0] f, logic [15:0] w);
    cfg_index <= CFG_FREQ_TOL;
    cfg_data  <= f;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    freq_tol = f;
    cfg_index <= CFG_WIDTH_TOL;
    cfg_data  <= CfgDataW'(w);
    do @(posedge clk); while (!cfg_ready);
    width_tol = w;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic rec_t mk_rec(logic [19:0] f, logic [31:0] c, logic [7:0] b,
                                  logic [15:0] w, logic [7:0] p, logic [63:0] n);
    rec_t r;
    r       = '0;
    r.freq  = f;
    r.code  = c;
    r.bits  = b;
    r.width = w;
    r.proto = p;
    r.name  = n;
    return r;
  endfunction

  function automatic logic [31:0] pick_target();
    if (hist_len > 0 && $urandom_range(0, 3) != 0)
      return hist[$urandom_range(0, hist_len - 1)].id;
    if ($urandom_range(0, 1) == 0) return id_counter - $urandom_range(1, 64);
    return $urandom;
  endfunction

  // records from small pools of codes, frequencies and widths, so that
  // near-duplicates and exact tolerance edges come up often
  function automatic rec_t rand_rec();
    logic [31:0] c;
    logic [19:0] f;
    logic [15:0] w;
    int          d;
    c = ($urandom_range(0, 2) != 0) ? 32'hA5A5_0000 + $urandom_range(0, 7) : $urandom;
    f = ($urandom_range(0, 3) != 0) ? 20'd433_000 + 20'($urandom_range(0, 3) * 100)
                                    : 20'($urandom);
    w = ($urandom_range(0, 3) != 0) ? 16'd350 + 16'($urandom_range(0, 2) * 60)
                                    : 16'($urandom);
    d = $urandom_range(0, 4);
    if (d == 1) f = f + freq_tol;
    if (d == 2) f = f - freq_tol - 20'd1;
    if (d == 3) w = w + width_tol;
    if (d == 4) w = w + width_tol + 16'd1;
    if ($urandom_range(0, 3) == 0) f = f + 20'($urandom_range(0, 40));
    return mk_rec(f, c, ($urandom_range(0, 3) != 0) ? 8'd32 : 8'($urandom), w,
                  8'($urandom), {$urandom, $urandom});
  endfunction

  task automatic rand_item();
    int          pick;
    logic [2:0]  act;
    pick = $urandom_range(0, 99);
    if (pick < 48)      act = OP_ADD;
    else if (pick < 68) act = OP_GET;
    else if (pick < 82) act = OP_REMOVE;
    else if (pick < 93) act = OP_RENAME;
    else if (pick < 96) act = OP_CLEAR;
    else                act = 3'($urandom_range(OP_BAD, 7));
    send_item(act, pick_target(), rand_rec());
  endtask

  // result checker: each taken result against the oldest expectation
  always @(posedge clk) begin
    answer_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, id %h", out_id);
      end else begin
        want = answers_due.pop_front();
        if (ok !== want.ok || out_id !== want.id || out_freq_khz !== want.rec.freq ||
            out_code !== want.rec.code || out_bits !== want.rec.bits ||
            out_width_us !== want.rec.width || out_protocol !== want.rec.proto ||
            out_name !== want.rec.name || entry_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp ok %b id %h f %h c %h b %h w %h p %h n %h cnt %0d",
                     want.ok, want.id, want.rec.freq, want.rec.code, want.rec.bits,
                     want.rec.width, want.rec.proto, want.rec.name, want.count);
            $display("          got ok %b id %h f %h c %h b %h w %h p %h n %h cnt %0d",
                     ok, out_id, out_freq_khz, out_code, out_bits, out_width_us,
                     out_protocol, out_name, entry_count);
          end
        end
      end
    end
  end

  // receiver: stall pattern per phase, plus the long hold-off when requested
  always @(posedge clk or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready   <= 1'b0;
      hold_cnt    = 0;
      stall_phase = 0;
    end else begin
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      stall_phase++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ((stall_phase % 23) < 9) ? 1'b0 : 1'b1;
        endcase
      end
    end
  end

  task automatic test_directed();
    rec_t base;
    rec_t ones;
    gap_mode   = 0;
    stall_mode = 0;
    base = mk_rec(20'd0, 32'd0, 8'd0, 16'd0, 8'd0, 64'd0);
    ones = mk_rec('1, '1, '1, '1, '1, '1);
    // lookups on an empty table
    send_item(OP_GET, 32'd1, base);
    send_item(OP_REMOVE, 32'd1, base);
    send_item(OP_RENAME, 32'd1, base);
    send_item(OP_ADD, '0, base);
    send_item(OP_ADD, '0, base);                                     // exact duplicate
    send_item(OP_ADD, '0, mk_rec(20'd50, 0, 0, 16'd20, 8'd7, '1));   // both at the limit
    send_item(OP_ADD, '0, mk_rec(20'd51, 0, 0, 16'd0, 0, 0));        // freq just outside
    send_item(OP_ADD, '0, mk_rec(20'd0, 0, 0, 16'd21, 0, 0));        // width just outside
    send_item(OP_ADD, '0, mk_rec(20'd0, 0, 8'd1, 16'd0, 0, 0));      // bits differ
    send_item(OP_ADD, '0, ones);
    send_item(OP_ADD, '0, mk_rec('1, '1, '1, 16'hFFEB, 8'd0, 64'd0)); // dup from above
    send_item(OP_GET, 32'd5, base);
    send_item(OP_GET, 32'd1, base);
    send_item(OP_GET, 32'hFFFF_FFFF, base);
    send_item(OP_RENAME, 32'd2, ones);
    send_item(OP_GET, 32'd2, base);
    send_item(OP_REMOVE, 32'd3, base);                               // middle entry
    send_item(OP_GET, 32'd4, base);
    send_item(OP_REMOVE, 32'd3, base);
    send_item(OP_BAD, 32'd1, ones);
    send_item(3'd6, '1, ones);
    send_item(3'd7, '0, base);
    send_item(OP_CLEAR, '0, base);
    send_item(OP_GET, 32'd1, base);
    send_item(OP_ADD, '0, ones);                                     // id counter kept
    drain();
  endtask

  // overfill so the oldest entries fall out, then look for the evicted ones
  task automatic test_eviction();
    gap_mode   = 1;
    stall_mode = 1;
    for (int i = 0; i < 40; i++)
      send_item(OP_ADD, '0, mk_rec(20'($urandom), 32'h1000 + i, 8'd24, 16'($urandom),
                                   8'($urandom), {$urandom, $urandom}));
    for (int i = 0; i < 10; i++) send_item(OP_GET, id_counter - 32'd1 - 32'(i * 4), '0);
    send_item(OP_REMOVE, id_counter - 32'd1, '0);
    send_item(OP_REMOVE, hist[hist_len-1].id, '0);
    drain();
  endtask

  // receiver holds off for a long while; the input must back up and stall
  task automatic test_backpressure();
    gap_mode   = 0;
    stall_mode = 0;
    hold_req   = 400;
    for (int i = 0; i < 24; i++) rand_item();
    drain();
  endtask

  task automatic test_random(int n, int gm, int sm);
    gap_mode   = gm;
    stall_mode = sm;
    for (int i = 0; i < n; i++) rand_item();
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; action = '0; target_id = '0; freq_khz = '0; code_value = '0;
    code_bits = '0; pulse_width_us = '0; protocol_num = '0; name_tag = '0;
    hold_req = 0; gap_mode = 0; stall_mode = 0; burst_left = 0;
    mismatches = 0; results_seen = 0; dup_seen = 0; evict_seen = 0;
    foreach (op_seen[i]) op_seen[i] = 0;
    hist_len = 0; id_counter = 32'd1;
    freq_tol = FreqTolReset; width_tol = WidthTolReset;
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_directed();
    test_eviction();
    test_backpressure();
    test_random(250, 1, 1);
    set_tolerances(20'd0, 16'd0);
    test_random(200, 2, 2);
    set_tolerances('1, '1);
    test_random(150, 1, 0);
    set_tolerances(20'd5, 16'd3);
    test_random(250, 0, 1);
    set_tolerances(20'd300, 16'd100);
    test_random(250, 2, 1);
    set_tolerances(FreqTolReset, WidthTolReset);
    test_random(100, 0, 0);

    $display("covered %0d results: add %0d get %0d remove %0d rename %0d clear %0d",
             results_seen, op_seen[OP_ADD], op_seen[OP_GET], op_seen[OP_REMOVE],
             op_seen[OP_RENAME], op_seen[OP_CLEAR]);
    $display("unknown actions %0d, duplicates %0d, evictions %0d, mismatches %0d",
             op_seen[5] + op_seen[6] + op_seen[7], dup_seen, evict_seen, mismatches);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### dedup_history_table.f
design/dht_pkg.sv
design/dht_front.sv
design/dht_queue.sv
design/dht_back.sv
design/dedup_history_table.sv
tb/tb.sv
